// ===== hdl/pcs_pkg.sv =====
package pcs_pkg;

  // Default depth of the offset history.
  localparam int unsigned WINDOW_DEFAULT = 8;

  localparam int unsigned TIME_W = 48;
  localparam int unsigned CFG_W  = 21;
  localparam int unsigned IDX_W  = 2;
  // Wide enough for sums and differences of two times plus a register value.
  localparam int unsigned WIDE_W = TIME_W + 2;

  // Input item layout.
  localparam int unsigned IN_DATA_W = 104;
  localparam int unsigned OUT_DATA_W = 48;

  // Command codes carried in the input item's tuser.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_JUMP_THRESHOLD     = 2'd0,
    REG_LEAD_CEILING       = 2'd1,
    REG_BACKSTEP_TOLERANCE = 2'd2
  } reg_index_t;

  localparam logic [CFG_W-1:0] JUMP_THRESHOLD_RESET     = 21'd49152;
  localparam logic [CFG_W-1:0] LEAD_CEILING_RESET       = 21'd22938;
  localparam logic [CFG_W-1:0] BACKSTEP_TOLERANCE_RESET = 21'd16384;

  localparam logic signed [WIDE_W-1:0] SAT_HI = 50'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [WIDE_W-1:0] SAT_LO = 50'sh3_8000_0000_0000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_take;
    logic pause;
    logic resume;
    logic scan_start;
    logic scan_step;
    logic judge;
    logic pred_sum;
    logic pred_clip;
    logic pred_hold;
    logic res_zero;
    logic res_last;
    logic out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_read;
    logic in_playing;
    logic fresh;
    logic playing;
    logic has_sample;
    logic ring_empty;
    logic scan_last;
    logic out_free;
  } dp_status_t;

  // Clamp a wide signed value into the 48-bit time range.
  function automatic logic signed [TIME_W-1:0] sat48(input logic signed [WIDE_W-1:0] v);
    if (v > SAT_HI) begin
      return SAT_HI[TIME_W-1:0];
    end else if (v < SAT_LO) begin
      return SAT_LO[TIME_W-1:0];
    end
    return v[TIME_W-1:0];
  endfunction

endpackage

// ===== hdl/pcs_ctrl.sv =====
module pcs_ctrl import pcs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_SCAN_END,
    ST_JUDGE,
    ST_PRED_SUM,
    ST_PRED_CLIP,
    ST_PRED_HOLD,
    ST_OUT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.in_take = 1'b1;
          state_next  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status.is_read) begin
          if (!status.has_sample) begin
            cmd.res_zero = 1'b1;
            state_next   = ST_OUT;
          end else if (!status.playing || status.ring_empty) begin
            cmd.res_last = 1'b1;
            state_next   = ST_OUT;
          end else begin
            cmd.scan_start = 1'b1;
            state_next     = ST_SCAN;
          end
        end else if (!status.in_playing) begin
          cmd.pause  = 1'b1;
          state_next = ST_IDLE;
        end else if (status.playing && !status.fresh) begin
          state_next = ST_IDLE;
        end else if (!status.playing || status.ring_empty) begin
          // A resume empties the ring, so, as with an already empty ring, no scan is needed.
          cmd.resume = !status.playing;
          state_next = ST_JUDGE;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_next = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        state_next = status.is_read ? ST_PRED_SUM : ST_JUDGE;
      end
      ST_JUDGE: begin
        cmd.judge  = 1'b1;
        state_next = ST_IDLE;
      end
      ST_PRED_SUM: begin
        cmd.pred_sum = 1'b1;
        state_next   = ST_PRED_CLIP;
      end
      ST_PRED_CLIP: begin
        cmd.pred_clip = 1'b1;
        state_next    = ST_PRED_HOLD;
      end
      ST_PRED_HOLD: begin
        cmd.pred_hold = 1'b1;
        state_next    = ST_OUT;
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/pcs_datapath.sv =====
module pcs_datapath import pcs_pkg::*; #(
  parameter int unsigned WINDOW_SAMPLES = WINDOW_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_command,
  input  logic [TIME_W-1:0]     in_position,
  input  logic [TIME_W-1:0]     in_now_time,
  input  logic                  in_playing,
  input  logic                  cfg_valid,
  input  logic [IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [TIME_W-1:0]     out_position,
  input  dp_cmd_t               cmd,
  output dp_status_t            status
);

  localparam int unsigned AW = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;
  localparam int unsigned CW = $clog2(WINDOW_SAMPLES + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW_SAMPLES - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(WINDOW_SAMPLES);

  // Configuration registers.
  logic [CFG_W-1:0] jump_threshold;
  logic [CFG_W-1:0] lead_ceiling;
  logic [CFG_W-1:0] backstep_tolerance;

  // Latched input item.
  logic              cmd_q;
  logic [TIME_W-1:0] pos_q;
  logic [TIME_W-1:0] now_q;
  logic              playing_q;

  // Smoother state.
  logic [TIME_W-1:0] offset_ring [WINDOW_SAMPLES];
  logic [CW-1:0]     ring_count;
  logic [AW-1:0]     ring_next;
  logic [TIME_W-1:0] last_position;
  logic              has_sample;
  logic              is_playing;
  logic [TIME_W-1:0] held_output;

  // Working registers.
  logic [TIME_W-1:0] off_q;
  logic [AW-1:0]     scan_idx;
  logic              scan_first;
  logic              rd_pend;
  logic [TIME_W-1:0] rd_data;
  logic [TIME_W-1:0] max_q;
  logic [WIDE_W-1:0] sum_q;
  logic [TIME_W-1:0] res_q;

  logic signed [WIDE_W-1:0] pos_x, now_x, last_x, held_x, max_x, off_x, res_x, sum_x;
  logic signed [WIDE_W-1:0] thr_x, ceil_x, tol_x;
  logic signed [WIDE_W-1:0] clip_v;
  logic jump, backstep, discard;
  logic [AW-1:0] slot_after;
  logic [AW-1:0] wr_addr;

  assign pos_x  = WIDE_W'($signed(pos_q));
  assign now_x  = WIDE_W'($signed(now_q));
  assign last_x = WIDE_W'($signed(last_position));
  assign held_x = WIDE_W'($signed(held_output));
  assign max_x  = WIDE_W'($signed(max_q));
  assign off_x  = WIDE_W'($signed(off_q));
  assign res_x  = WIDE_W'($signed(res_q));
  assign sum_x  = $signed(sum_q);
  assign thr_x  = $signed({{(WIDE_W-CFG_W){1'b0}}, jump_threshold});
  assign ceil_x = $signed({{(WIDE_W-CFG_W){1'b0}}, lead_ceiling});
  assign tol_x  = $signed({{(WIDE_W-CFG_W){1'b0}}, backstep_tolerance});

  assign status.is_read    = (cmd_q == CMD_READ);
  assign status.in_playing = playing_q;
  assign status.fresh      = !has_sample || (pos_q != last_position);
  assign status.playing    = is_playing;
  assign status.has_sample = has_sample;
  assign status.ring_empty = (ring_count == '0);
  assign status.scan_last  = (CW'(scan_idx) == ring_count - 1'b1);
  assign status.out_free   = !out_valid || out_ready;

  assign jump     = (ring_count != '0) && ((off_x - max_x > thr_x) || (max_x - off_x > thr_x));
  assign backstep = has_sample && (pos_x < last_x - tol_x);
  assign discard  = jump || backstep;
  assign wr_addr  = discard ? '0 : ring_next;
  assign slot_after = (wr_addr == LAST_SLOT) ? '0 : wr_addr + 1'b1;

  always_comb begin
    clip_v = sum_x;
    if (clip_v > last_x + ceil_x) begin
      clip_v = last_x + ceil_x;
    end
    if (clip_v < last_x - tol_x) begin
      clip_v = last_x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      jump_threshold     <= JUMP_THRESHOLD_RESET;
      lead_ceiling       <= LEAD_CEILING_RESET;
      backstep_tolerance <= BACKSTEP_TOLERANCE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_JUMP_THRESHOLD:     jump_threshold     <= cfg_data;
        REG_LEAD_CEILING:       lead_ceiling       <= cfg_data;
        REG_BACKSTEP_TOLERANCE: backstep_tolerance <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input latch, offset and prediction arithmetic.
  always_ff @(posedge clk) begin
    if (cmd.in_take) begin
      cmd_q     <= in_command;
      pos_q     <= in_position;
      now_q     <= in_now_time;
      playing_q <= in_playing;
    end
    off_q <= sat48(pos_x - now_x);
    if (cmd.pred_sum) begin
      sum_q <= now_x + max_x;
    end
    if (cmd.res_zero) begin
      res_q <= '0;
    end else if (cmd.res_last) begin
      res_q <= last_position;
    end else if (cmd.pred_clip) begin
      res_q <= sat48(clip_v);
    end else if (cmd.pred_hold) begin
      if ((res_x < held_x) && (held_x - res_x < tol_x)) begin
        res_q <= held_output;
      end
    end
  end

  // Ring memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.judge) begin
      offset_ring[wr_addr] <= off_q;
    end
    if (cmd.scan_step) begin
      rd_data <= offset_ring[scan_idx];
    end
  end

  // Running maximum over the occupied ring entries.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.scan_step;
    end
    if (cmd.scan_start) begin
      scan_idx   <= '0;
      scan_first <= 1'b1;
    end else begin
      if (cmd.scan_step) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (rd_pend) begin
        scan_first <= 1'b0;
        if (scan_first || ($signed(rd_data) > $signed(max_q))) begin
          max_q <= rd_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_count    <= '0;
      ring_next     <= '0;
      last_position <= '0;
      has_sample    <= 1'b0;
      is_playing    <= 1'b0;
      held_output   <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.pause) begin
        is_playing    <= 1'b0;
        ring_count    <= '0;
        ring_next     <= '0;
        last_position <= pos_q;
        has_sample    <= 1'b1;
        held_output   <= pos_q;
      end
      if (cmd.resume) begin
        is_playing <= 1'b1;
        ring_count <= '0;
        ring_next  <= '0;
      end
      if (cmd.judge) begin
        if (discard) begin
          held_output <= pos_q;
          ring_count  <= CW'(1);
        end else if (ring_count != FULL_COUNT) begin
          ring_count <= ring_count + 1'b1;
        end
        ring_next     <= slot_after;
        last_position <= pos_q;
        has_sample    <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid   <= 1'b1;
        held_output <= res_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_position <= res_q;
    end
  end

endmodule

// ===== hdl/playback_clock_smoother.sv =====
// Playback clock smoother. Each input item is either a position sample (tuser 0) or a
// read request (tuser 1); times are signed Q16 seconds, 48 bits. A sample records the
// offset of playback position over wall time in a ring of the last WINDOW_SAMPLES
// offsets and produces no output item. A read produces one output item: wall time plus
// the largest recorded offset, limited to lead_ceiling ahead of the last sampled
// position, pulled back to that position when it falls more than backstep_tolerance
// below it, and held against small backward steps. Reads before any sample give zero,
// and reads while paused or with an empty ring give the last sampled position.
// Items are handled one at a time. A sample that needs the ring maximum scans the
// ring, one entry per cycle through its single read port, and then judges its
// offset; a read that needs it scans the ring and then sums, clips and holds the
// prediction. Paused samples, repeated positions and samples into an empty ring,
// including the first one after a pause, skip the scan, and so do reads before any
// sample, while paused or with an empty ring. A finished read result sits in an
// output register, so the next item is accepted while it waits to be taken; a
// further read then holds in its last step until that register is free.
// Configuration writes are always accepted and must only be issued while idle.
module playback_clock_smoother import pcs_pkg::*; #(
  parameter int unsigned WINDOW_SAMPLES = WINDOW_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input items.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata, from bit 0 up: position[47:0], now_time[95:48], playing[96], zero[103:97].
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: command (0 sample, 1 read).
  input  logic                  s_axis_tuser,
  // Output items.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata, from bit 0 up: smoothed_position[47:0].
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // Configuration writes.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Registers can be written on any cycle.
  assign cfg_ready = 1'b1;

  // The controller sequences the ring scan and the judge or prediction steps.
  pcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the ring, the smoother state and the output register.
  pcs_datapath #(
    .WINDOW_SAMPLES (WINDOW_SAMPLES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .in_command   (s_axis_tuser),
    .in_position  (s_axis_tdata[TIME_W-1:0]),
    .in_now_time  (s_axis_tdata[2*TIME_W-1:TIME_W]),
    .in_playing   (s_axis_tdata[2*TIME_W]),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_position (m_axis_tdata),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

// ===== bench/smoother_sb_pkg.sv =====
package smoother_sb_pkg;
  import pcs_pkg::*;

  typedef logic signed [TIME_W-1:0] q16_t;

  localparam longint Q16_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint Q16_LO = -Q16_HI - 64'sd1;
  localparam int unsigned WINDOW = WINDOW_DEFAULT;
  localparam int unsigned REPORT_LIMIT = 10;

  class position_scoreboard;
    // Mirror of the smoother state.
    q16_t        offsets[WINDOW];
    int unsigned fill;
    int unsigned slot;
    q16_t        last_pos;
    q16_t        held_pos;
    bit          have_sample;
    bit          running;
    longint      jump_thr;
    longint      lead_max;
    longint      back_tol;

    q16_t        expected_pos[$];
    int unsigned failures;

    function new();
      jump_thr    = longint'(JUMP_THRESHOLD_RESET);
      lead_max    = longint'(LEAD_CEILING_RESET);
      back_tol    = longint'(BACKSTEP_TOLERANCE_RESET);
      fill        = 0;
      slot        = 0;
      last_pos    = '0;
      held_pos    = '0;
      have_sample = 1'b0;
      running     = 1'b0;
      failures    = 0;
    endfunction

    function void write_reg(reg_index_t idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_JUMP_THRESHOLD:     jump_thr = longint'(value);
        REG_LEAD_CEILING:       lead_max = longint'(value);
        REG_BACKSTEP_TOLERANCE: back_tol = longint'(value);
        default: ;
      endcase
    endfunction

    function q16_t clamp_q16(longint v);
      if (v > Q16_HI) begin
        v = Q16_HI;
      end else if (v < Q16_LO) begin
        v = Q16_LO;
      end
      return v[TIME_W-1:0];
    endfunction

    function longint window_peak();
      longint peak;
      peak = longint'(offsets[0]);
      for (int unsigned i = 1; i < fill; i++) begin
        if (longint'(offsets[i]) > peak) peak = longint'(offsets[i]);
      end
      return peak;
    endfunction

    function void take_sample(q16_t pos, q16_t now, logic play);
      bit     fresh;
      bit     restart;
      q16_t   off;
      longint peak;
      fresh = !have_sample || pos != last_pos;
      if (!play) begin
        running     = 1'b0;
        fill        = 0;
        slot        = 0;
        last_pos    = pos;
        held_pos    = pos;
        have_sample = 1'b1;
        return;
      end
      // First sample after a pause always starts a new history.
      if (!running) begin
        running = 1'b1;
        fill    = 0;
        slot    = 0;
        fresh   = 1'b1;
      end
      if (!fresh) return;
      off     = clamp_q16(longint'(pos) - longint'(now));
      restart = 1'b0;
      if (fill != 0) begin
        peak    = window_peak();
        restart = (longint'(off) - peak > jump_thr) || (peak - longint'(off) > jump_thr);
      end
      if (!restart && have_sample && longint'(pos) < longint'(last_pos) - back_tol) begin
        restart = 1'b1;
      end
      if (restart) begin
        fill     = 0;
        slot     = 0;
        held_pos = pos;
      end
      offsets[slot] = off;
      slot          = (slot + 1) % WINDOW;
      if (fill < WINDOW) fill++;
      last_pos    = pos;
      have_sample = 1'b1;
    endfunction

    function q16_t predict_read(q16_t now);
      longint v;
      longint last;
      longint held;
      if (!have_sample) return '0;
      if (!running || fill == 0) begin
        held_pos = last_pos;
        return last_pos;
      end
      last = longint'(last_pos);
      held = longint'(held_pos);
      v    = longint'(now) + window_peak();
      if (v > last + lead_max) v = last + lead_max;
      if (v < last - back_tol) v = last;
      v = longint'(clamp_q16(v));
      if (v < held && held - v < back_tol) v = held;
      held_pos = v[TIME_W-1:0];
      return held_pos;
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("%s", msg);
    endfunction

    function void note_item(logic cmd, q16_t pos, q16_t now, logic play);
      if (cmd == CMD_READ) begin
        expected_pos.push_back(predict_read(now));
      end else begin
        take_sample(pos, now, play);
      end
    endfunction

    function void check_position(logic [TIME_W-1:0] seen);
      q16_t want;
      if (expected_pos.size() == 0) begin
        report($sformatf("smoothed_position %0d arrived with no read outstanding",
                         $signed(seen)));
        return;
      end
      want = expected_pos.pop_front();
      if (seen !== want) begin
        report($sformatf("smoothed_position: expected %0d, got %0d", want, $signed(seen)));
      end
    endfunction

    function int pending();
      return expected_pos.size();
    endfunction

    function void finish_check();
      if (expected_pos.size() != 0) begin
        report($sformatf("%0d smoothed_position items never arrived", expected_pos.size()));
      end
    endfunction
  endclass

endpackage

// ===== bench/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pcs_pkg::*;
  import smoother_sb_pkg::*;

  // Q16 seconds, and one video frame at 60 Hz.
  localparam longint      SEC           = 64'sd65536;
  localparam int unsigned FRAME         = 1092;
  localparam longint      Q16_TOP       = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint      Q16_BOTTOM    = -Q16_TOP - 64'sd1;
  localparam int unsigned CFG_HIGH      = 1048576;
  localparam int unsigned PHASE_ITEMS   = 215;
  // This covers even the slowest item, so also the tail of any sample still
  // in flight once the last read has come back.
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned HOLD_CYCLES   = 400;
  // The longest legal stretch with no handshake at all is the receiver
  // hold-off plus a settle pause plus one slow item; allow several times that.
  localparam int unsigned STALL_LIMIT   = 2000;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = CMD_SAMPLE;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [IDX_W-1:0]      cfg_index     = REG_JUMP_THRESHOLD;
  logic [CFG_W-1:0]      cfg_data      = '0;

  position_scoreboard sb = new();

  // Both sides stop idling while this is set; the receiver goes quiet for a
  // long stretch once hold_req is raised.
  bit          steady       = 1'b0;
  bit          hold_req     = 1'b0;
  int unsigned quiet_cycles = 0;

  // Model of the media pipeline that the stimulus follows: a wall clock and
  // the lead of the playback position over it.
  longint wall;
  longint lead;
  longint last_sent;

  always #5 clk = ~clk;

  playback_clock_smoother u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Every handshake is observed here, at the edge where it happens. Input
  // items feed the predictor, output items are checked against it, and any
  // handshake resets the stall counter of the watchdog.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(reg_index_t'(cfg_index), cfg_data);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_item(s_axis_tuser, s_axis_tdata[TIME_W-1:0],
                     s_axis_tdata[2*TIME_W-1:TIME_W], s_axis_tdata[2*TIME_W]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_position(m_axis_tdata);
      end
      if ((cfg_valid && cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
          (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver: takes output items with random stalls, and once during the run
  // refuses everything for HOLD_CYCLES so that a finished read backs up into
  // the input side.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_axis_tready <= steady || ($urandom_range(99) >= 22);
    end
  end

  function automatic longint rand_q16();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return longint'($signed(r[TIME_W-1:0]));
  endfunction

  function automatic longint spread(input int unsigned mag);
    return longint'($urandom_range(2 * mag)) - longint'(mag);
  endfunction

  // Small register values half the time, where they interact with frame jitter,
  // and otherwise anything up to CFG_HIGH, which is 2**20.
  function automatic logic [CFG_W-1:0] rand_cfg();
    if ($urandom_range(1) == 0) return CFG_W'($urandom_range(100000));
    return CFG_W'($urandom_range(CFG_HIGH));
  endfunction

  // Presents one item, now and then after a random gap of idle cycles. The valid stays
  // high on return; the next call or a settle pause decides what follows.
  task automatic send_item(input logic cmd, input longint pos, input longint now,
                           input logic play);
    int unsigned gap;
    gap = 0;
    if (!steady && $urandom_range(99) < 22) gap = $urandom_range(16, 1);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {{(IN_DATA_W - 2*TIME_W - 1){1'b0}}, play,
                      now[TIME_W-1:0], pos[TIME_W-1:0]};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_sample(input longint pos, input longint now, input logic play);
    send_item(CMD_SAMPLE, pos, now, play);
  endtask

  // A read ignores position and playing, so those bits carry noise.
  task automatic send_read(input longint now);
    send_item(CMD_READ, rand_q16(), now, 1'($urandom_range(1)));
  endtask

  // Stops offering items, waits for every outstanding read to come back,
  // then lets a possible trailing sample finish inside the block.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] ceil,
                            input logic [CFG_W-1:0] tol);
    write_reg(REG_JUMP_THRESHOLD, thr);
    write_reg(REG_LEAD_CEILING, ceil);
    write_reg(REG_BACKSTEP_TOLERANCE, tol);
    cfg_valid <= 1'b0;
  endtask

  // One playing frame: the wall clock advances by up to two frames, the
  // position follows it with a little jitter, and the sample's timestamp
  // jitters by up to the given amount.
  task automatic play_frame(input int unsigned jitter);
    longint pos;
    wall = wall + longint'($urandom_range(2 * FRAME));
    pos  = wall + lead + spread(300);
    send_sample(pos, wall + spread(jitter), 1'b1);
    last_sent = pos;
  endtask

  // Random traffic, mostly well-formed playback: frames and reads, with
  // repeats, pauses, jumps, backward steps, relocations to the edges of the
  // time range, and a little pure noise. Halfway through, the sender can
  // pause until all reads are answered, or the receiver can be told to hold.
  task automatic run_phase(input int unsigned count, input bit pause_mid,
                           input bit hold_mid);
    int unsigned n;
    int unsigned pick;
    int unsigned jit;
    for (n = 0; n < count; n++) begin
      if (n == count / 2) begin
        if (pause_mid) settle();
        if (hold_mid) hold_req = 1'b1;
      end
      pick = $urandom_range(99);
      jit  = ($urandom_range(9) == 0) ? 70000 : 800;
      if (pick < 38) begin
        send_read(wall + spread(($urandom_range(3) == 0) ? 150000 : 3000));
      end else if (pick < 78) begin
        play_frame(jit);
      end else if (pick < 82) begin
        send_sample(last_sent, wall + spread(800), 1'b1);
      end else if (pick < 85) begin
        last_sent = last_sent + spread(500);
        send_sample(last_sent, wall + spread(800), 1'b0);
      end else if (pick < 89) begin
        lead = lead + spread(1200000);
        play_frame(jit);
      end else if (pick < 93) begin
        lead = lead - longint'($urandom_range(100000));
        play_frame(jit);
      end else if (pick < 96) begin
        case ($urandom_range(2))
          0:       wall = Q16_TOP - longint'($urandom_range(200000));
          1:       wall = Q16_BOTTOM + longint'($urandom_range(200000));
          default: wall = rand_q16();
        endcase
        lead = spread(500000);
        play_frame(jit);
      end else begin
        send_item(1'($urandom_range(1)), rand_q16(), rand_q16(), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, with the registers at their reset values.
    // Reads before any sample answer zero.
    send_read(0);
    send_read(Q16_TOP);
    // The first sample's offset saturates high, and so does the read after it.
    send_sample(Q16_TOP, Q16_BOTTOM, 1'b1);
    send_read(Q16_TOP);
    // The same position again while playing changes nothing.
    send_sample(Q16_TOP, 0, 1'b1);
    // A paused sample, then a read while paused.
    send_sample(1000, 5, 1'b0);
    send_read(7);
    // Resuming far below is a backward step; the offset saturates low and
    // the next prediction saturates low as well.
    send_sample(Q16_BOTTOM, 100, 1'b1);
    send_read(-100);
    // Ordinary playback five seconds ahead of the wall clock; the first of
    // these is a jump away from the saturated offset.
    send_sample(10*SEC, 5*SEC, 1'b1);
    send_sample(10*SEC + FRAME, 5*SEC + FRAME, 1'b1);
    send_sample(10*SEC + 2*FRAME, 5*SEC + 2*FRAME, 1'b1);
    send_read(5*SEC + 2*FRAME + 500);
    // Far ahead: capped by the lead ceiling.
    send_read(8*SEC);
    // Far behind: falls back to the last position.
    send_read(4*SEC);
    // A small step backward is held at the previous answer.
    send_read(5*SEC + 2*FRAME - 200);
    // The offset moves by a full second: the history is dropped.
    send_sample(10*SEC + 3*FRAME, 4*SEC + 3*FRAME, 1'b1);
    // Same offset, but the position steps back half a second.
    send_sample(10*SEC + 3*FRAME - SEC/2, 3*SEC + 3*FRAME + SEC/2, 1'b1);
    send_read(3*SEC + 3*FRAME + SEC/2);
    send_sample(10*SEC + 4*FRAME, 4*SEC + 4*FRAME, 1'b0);
    send_read(4*SEC + 4*FRAME);

    wall      = 4*SEC + 4*FRAME;
    lead      = 6*SEC;
    last_sent = 10*SEC + 4*FRAME;

    run_phase(PHASE_ITEMS, 1'b0, 1'b0);

    // Any offset unlike the ring maximum is a jump; reads follow the last position.
    settle();
    set_config('0, '0, '0);
    run_phase(PHASE_ITEMS, 1'b0, 1'b0);

    // Registers at CFG_HIGH, and the long receiver hold-off.
    settle();
    set_config(CFG_W'(CFG_HIGH), CFG_W'(CFG_HIGH), CFG_W'(CFG_HIGH));
    run_phase(PHASE_ITEMS, 1'b0, 1'b1);

    // A stretch with no idling on either side.
    settle();
    steady = 1'b1;
    set_config(rand_cfg(), rand_cfg(), rand_cfg());
    run_phase(PHASE_ITEMS, 1'b0, 1'b0);
    steady = 1'b0;

    // No lead allowed at all; the sender drains the block halfway through.
    settle();
    set_config(CFG_W'(CFG_HIGH), '0, rand_cfg());
    run_phase(PHASE_ITEMS, 1'b1, 1'b0);

    settle();
    set_config(rand_cfg(), rand_cfg(), rand_cfg());
    run_phase(PHASE_ITEMS, 1'b0, 1'b0);

    settle();
    set_config(JUMP_THRESHOLD_RESET, LEAD_CEILING_RESET, BACKSTEP_TOLERANCE_RESET);
    run_phase(PHASE_ITEMS, 1'b0, 1'b0);

    settle();
    sb.finish_check();
    if (sb.failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/pcs_pkg.sv
hdl/pcs_ctrl.sv
hdl/pcs_datapath.sv
hdl/playback_clock_smoother.sv
bench/smoother_sb_pkg.sv
bench/tb_top.sv
